// ----- rtl/wfsp_pkg.sv -----
// Package for the waypoint follower: widths, reset values, CORDIC angle table.
// No dependencies.
`default_nettype none
package wfsp_pkg;
  localparam int unsigned TableDepth  = 64;
  localparam int unsigned CordicSteps = 16;
  localparam logic [15:0] MaxSpeedRst = 16'd2000;
  localparam logic [15:0] MinSpeedRst = 16'd500;
  localparam logic [31:0] BrakeRst    = 32'd196608;
  localparam logic [31:0] SwitchRst   = 32'd32768;
  localparam logic [15:0] BrakeStep   = 16'd50;
  localparam logic [15:0] FullTurn    = 16'd46080;

  typedef enum logic [2:0] {
    REG_MAX = 3'd0, REG_MIN = 3'd1, REG_BRAKE = 3'd2,
    REG_SWITCH = 3'd3, REG_FIRST = 3'd4, REG_LAST = 3'd5
  } reg_idx_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0: v = 22'd2949120;  5'd1: v = 22'd1740967; 5'd2: v = 22'd919879;
      5'd3: v = 22'd466945;   5'd4: v = 22'd234379;  5'd5: v = 22'd117304;
      5'd6: v = 22'd58666;    5'd7: v = 22'd29335;   5'd8: v = 22'd14668;
      5'd9: v = 22'd7334;     5'd10: v = 22'd3667;   5'd11: v = 22'd1833;
      5'd12: v = 22'd917;     5'd13: v = 22'd458;    5'd14: v = 22'd229;
      5'd15: v = 22'd115;     5'd16: v = 22'd57;     5'd17: v = 22'd29;
      5'd18: v = 22'd14;      5'd19: v = 22'd7;      5'd20: v = 22'd4;
      5'd21: v = 22'd2;       5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/wfsp_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module wfsp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/waypoint_follower_speed_profile.sv -----
// Top level of the waypoint follower: APB registers, waypoint RAMs, sequencer
// with a CORDIC, a bit-serial square root and a bit-serial divider.
// Depends on wfsp_pkg and wfsp_ram.
//
// channel | ports                               | timing
// cfg     | psel penable pwrite paddr pwdata ... | write at access cycle, no waits
// in      | start busy in_*                      | taken when start & !busy
// out     | out_valid out_*                      | one-cycle strobe, no backpressure
//
// A load, a braking tick or a tick on an invalid route goes straight to S_OUT,
// which raises the strobe. A tick on an active route computes the bearing to
// the current point (normalize, then CORDIC_STEPS rotations), squares serially,
// takes the root, scales and divides, then, if a next point exists, computes the
// bearing of the next leg the same way before the final sequencing in S_FIN.
// Reset is synchronous; the waypoint tables are not cleared.
`default_nettype none
module waypoint_follower_speed_profile #(
  parameter int unsigned TABLE_DEPTH  = wfsp_pkg::TableDepth,
  parameter int unsigned CORDIC_STEPS = wfsp_pkg::CordicSteps
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_command,
  input  wire logic [5:0]  in_point_index,
  input  wire logic [31:0] in_point_x,
  input  wire logic [31:0] in_point_y,
  input  wire logic [31:0] in_position_x,
  input  wire logic [31:0] in_position_y,
  input  wire logic        in_heading_reached,
  output logic             out_valid,
  output logic [15:0]      out_target_heading,
  output logic [15:0]      out_target_velocity,
  output logic [6:0]       out_waypoint_now,
  output logic             out_arrived,
  output logic             out_route_done
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001, S_RD0 = 16'h0002, S_RD1  = 16'h0004, S_RD2 = 16'h0008,
    S_NORM  = 16'h0010, S_ROT = 16'h0020, S_QUAD = 16'h0040, S_SQ  = 16'h0080,
    S_SQRT  = 16'h0100, S_DIVP = 16'h0200, S_DIV = 16'h0400, S_FIN = 16'h0800,
    S_OUT   = 16'h1000, S_MUL = 16'h2000, S_RDN = 16'h4000
  } st_t;

  // ---------------- configuration registers
  logic [15:0] max_r, min_r;
  logic [31:0] brake_r, sw_r;
  logic [5:0]  first_r, last_r;
  logic [6:0]  cur_r;
  logic        latch_r;
  logic [15:0] hdg_r, vel_r;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[4:2])
      wfsp_pkg::REG_MAX:    prdata = {16'd0, max_r};
      wfsp_pkg::REG_MIN:    prdata = {16'd0, min_r};
      wfsp_pkg::REG_BRAKE:  prdata = brake_r;
      wfsp_pkg::REG_SWITCH: prdata = sw_r;
      wfsp_pkg::REG_FIRST:  prdata = {26'd0, first_r};
      wfsp_pkg::REG_LAST:   prdata = {26'd0, last_r};
      default:              prdata = 32'd0;
    endcase
  end

  // ---------------- waypoint tables
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   xr, yr;
  wfsp_ram #(.Width(32), .Depth(TABLE_DEPTH)) u_xram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_point_x), .rdata(xr));
  wfsp_ram #(.Width(32), .Depth(TABLE_DEPTH)) u_yram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_point_y), .rdata(yr));

  // ---------------- datapath registers
  st_t st_r;
  logic        pass_r;         // 0: bearing to point, 1: next leg
  logic        hok_r, has_next_r;
  logic signed [32:0] px_r, py_r, wx_r, wy_r;
  logic signed [33:0] dx_r, dy_r, dx0_r, dy0_r;
  logic signed [43:0] cx_r, cy_r;
  logic signed [24:0] z_r;
  logic [4:0]  it_r;
  logic [15:0] ang_r, next_r;
  logic [63:0] sq_r;           // sum of squares
  logic        sat_r;
  logic [32:0] root_r;
  logic [65:0] rem_r;
  logic [5:0]  rit_r;
  logic [6:0]  mit_r;
  logic [32:0] d_r;
  logic [33:0] mul_a_r;        // multiplicand, shifted
  logic [63:0] prod_r;
  logic [15:0] mul_b_r;
  logic [69:0] num_r;          // numerator, shifted out msb first
  logic [69:0] q_r;
  logic [36:0] den_r;
  logic [37:0] drem_r;

  logic [32:0] ax, ay;
  assign ax = dx_r[33] ? 33'(-dx_r) : dx_r[32:0];
  assign ay = dy_r[33] ? 33'(-dy_r) : dy_r[32:0];

  logic signed [43:0] xs, ys;
  assign xs = cx_r >>> it_r;
  assign ys = cy_r >>> it_r;

  logic [65:0] trial;
  assign trial = {rem_r[63:0], sq_r[63:62]};
  logic [34:0] tsub;
  assign tsub = {1'b0, root_r[31:0], 2'b01};

  logic [37:0] dsh;
  assign dsh = {drem_r[36:0], num_r[69]};

  // quadrant mapping and rounding of the clamped angle
  logic [24:0] zc, aq;
  logic [15:0] hq;
  always_comb begin
    zc = z_r[24] ? 25'd0 : ((z_r > 25'sd5898240) ? 25'd5898240 : 25'(z_r));
    if (!dx0_r[33] && !dy0_r[33]) aq = zc;
    else if (dx0_r[33] && !dy0_r[33]) aq = 25'd11796480 - zc;
    else if (dx0_r[33]) aq = 25'd11796480 + zc;
    else aq = 25'd23592960 - zc;
    hq = 16'((aq + 25'd256) >> 9);
    if (hq >= wfsp_pkg::FullTurn) hq = hq - wfsp_pkg::FullTurn;
  end

  assign busy = (st_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= wfsp_pkg::MaxSpeedRst; min_r <= wfsp_pkg::MinSpeedRst;
      brake_r <= wfsp_pkg::BrakeRst;  sw_r <= wfsp_pkg::SwitchRst;
      first_r <= '0; last_r <= '0; cur_r <= '0; latch_r <= 1'b0;
      hdg_r <= '0; vel_r <= '0; st_r <= S_IDLE; out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_wr) begin
        case (paddr[4:2])
          wfsp_pkg::REG_MAX:    max_r <= pwdata[15:0];
          wfsp_pkg::REG_MIN:    min_r <= pwdata[15:0];
          wfsp_pkg::REG_BRAKE:  brake_r <= pwdata;
          wfsp_pkg::REG_SWITCH: sw_r <= pwdata;
          wfsp_pkg::REG_FIRST: begin
            first_r <= pwdata[5:0]; cur_r <= {1'b0, pwdata[5:0]}; latch_r <= 1'b0;
          end
          wfsp_pkg::REG_LAST:   last_r <= pwdata[5:0];
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: begin
          if (start) begin
            hok_r <= in_heading_reached;
            px_r <= 33'(signed'(in_position_x));
            py_r <= 33'(signed'(in_position_y));
            if (!in_command) st_r <= S_OUT;
            else if (cur_r > {1'b0, last_r}) begin
              if (vel_r < min_r) vel_r <= '0;
              else vel_r <= (vel_r >= wfsp_pkg::BrakeStep) ? vel_r - wfsp_pkg::BrakeStep : '0;
              st_r <= S_OUT;
            end else if (first_r >= last_r) st_r <= S_OUT;
            else st_r <= S_RD0;
          end
        end
        S_RD0: begin // address current issued
          has_next_r <= (cur_r < {1'b0, last_r});
          pass_r <= 1'b0;
          st_r <= S_RD1;
        end
        S_RD1: begin // current point data
          wx_r <= 33'(signed'(xr)); wy_r <= 33'(signed'(yr));
          dx_r <= 34'(signed'(xr)) - 34'(px_r);
          dy_r <= 34'(signed'(yr)) - 34'(py_r);
          dx0_r <= 34'(signed'(xr)) - 34'(px_r);
          dy0_r <= 34'(signed'(yr)) - 34'(py_r);
          sq_r <= '0; st_r <= S_SQ; it_r <= '0;
        end
        S_SQ: begin // start of bearing for (dx,dy)
          cx_r <= 44'(ax); cy_r <= 44'(ay);
          st_r <= (ax == 0 && ay == 0) ? S_QUAD : S_NORM;
          z_r <= '0;
        end
        S_NORM: begin
          if ((cx_r | cy_r) < 44'sh100_0000_0000) begin
            cx_r <= cx_r <<< 1; cy_r <= cy_r <<< 1;
          end else begin
            it_r <= '0; st_r <= S_ROT;
          end
        end
        S_ROT: begin
          if (!cy_r[43]) begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs;
            z_r <= z_r + 25'(wfsp_pkg::atan_lut(it_r));
          end else begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs;
            z_r <= z_r - 25'(wfsp_pkg::atan_lut(it_r));
          end
          if (32'(it_r) == CORDIC_STEPS - 1) st_r <= S_QUAD;
          it_r <= it_r + 5'd1;
        end
        S_QUAD: begin
          if (!pass_r) begin
            ang_r <= (dx_r == 0 && dy_r == 0) ? 16'd0 : hq;
            // squares by serial multiply
            mul_a_r <= {1'b0, ax}; mul_b_r <= '0; prod_r <= '0;
            num_r <= {37'd0, ay}; mit_r <= '0; sq_r <= '0; sat_r <= 1'b0;
            st_r <= S_MUL;
          end else begin
            next_r <= (dx_r == 0 && dy_r == 0) ? 16'd0 : hq;
            st_r <= S_FIN;
          end
        end
        S_MUL: begin // shift-add: ax*ax, then ay*ay
          if (mit_r < 7'd33) begin
            if (ax[mit_r[5:0]]) prod_r <= prod_r + (64'(ax) << mit_r[5:0]);
          end else begin
            if (ay[6'(mit_r - 7'd33)]) prod_r <= prod_r + (64'(ay) << 6'(mit_r - 7'd33));
          end
          if (mit_r == 7'd32) begin
            sq_r <= prod_r + ((ax[32]) ? (64'(ax) << 32) : 64'd0); prod_r <= '0;
          end
          if (mit_r == 7'd65) begin
            logic [64:0] s;
            s = 65'(sq_r) + 65'(prod_r) + ((ay[32]) ? (65'(ay) << 32) : 65'd0);
            sat_r <= s[64]; sq_r <= s[63:0];
            rem_r <= '0; root_r <= '0; rit_r <= '0; st_r <= S_SQRT;
          end
          mit_r <= mit_r + 7'd1;
        end
        S_SQRT: begin // restoring root, 2 bits per cycle
          if (trial >= 66'(tsub)) begin
            rem_r <= trial - 66'(tsub); root_r <= {root_r[31:0], 1'b1};
          end else begin
            rem_r <= trial; root_r <= {root_r[31:0], 1'b0};
          end
          sq_r <= sq_r << 2;
          if (rit_r == 6'd31) st_r <= S_DIVP;
          rit_r <= rit_r + 6'd1;
        end
        S_DIVP: begin
          d_r <= sat_r ? 33'h1_0000_0000 : root_r;
          mul_a_r <= {1'b0, sat_r ? 33'h1_0000_0000 : root_r};
          mul_b_r <= max_r - min_r; prod_r <= '0; mit_r <= '0;
          den_r <= 37'(brake_r) * 37'd10;
          st_r <= S_DIV;
          drem_r <= '0; q_r <= '0;
        end
        S_DIV: begin // serial multiply, then restoring divide
          if (mit_r < 7'd16) begin
            if (mul_b_r[mit_r[3:0]]) prod_r <= prod_r + (64'(mul_a_r) << mit_r[3:0]);
            if (mit_r == 7'd15) num_r <= 70'(prod_r + (mul_b_r[15] ? (64'(mul_a_r) << 15) : 64'd0)) * 70'd7;
            mit_r <= mit_r + 7'd1;
          end else begin
            if (dsh >= 38'(den_r)) begin
              drem_r <= dsh - 38'(den_r); q_r <= {q_r[68:0], 1'b1};
            end else begin
              drem_r <= dsh; q_r <= {q_r[68:0], 1'b0};
            end
            num_r <= num_r << 1;
            if (mit_r == 7'd85) begin
              st_r <= S_RD2; pass_r <= 1'b1;
            end
            mit_r <= mit_r + 7'd1;
          end
        end
        S_RD2: begin // next entry is taken in S_RDN
          st_r <= has_next_r ? S_RDN : S_FIN;
          if (!has_next_r) next_r <= hdg_r;
        end
        S_RDN: begin
          dx_r <= 34'(signed'(xr)) - 34'(wx_r);
          dy_r <= 34'(signed'(yr)) - 34'(wy_r);
          dx0_r <= 34'(signed'(xr)) - 34'(wx_r);
          dy0_r <= 34'(signed'(yr)) - 34'(wy_r);
          st_r <= S_SQ;
        end
        S_FIN: begin
          logic lt;
          logic [15:0] sp;
          lt = latch_r;
          if (d_r > 33'(brake_r)) sp = max_r;
          else if (max_r <= min_r || brake_r == 0) sp = min_r;
          else sp = min_r + q_r[15:0];
          if (!latch_r) begin hdg_r <= ang_r; vel_r <= sp; end
          if (d_r < 33'(sw_r)) lt = 1'b1;
          latch_r <= lt;
          if (lt) begin
            hdg_r <= next_r; vel_r <= min_r;
            if (hok_r) begin cur_r <= cur_r + 7'd1; latch_r <= 1'b0; end
          end
          st_r <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // RAM address: load slot on accept, current or next waypoint during a tick
  always_comb begin
    ram_we = (st_r == S_IDLE) && start && !in_command &&
             (32'(in_point_index) < TABLE_DEPTH);
    if (st_r == S_IDLE) ram_addr = AW'(in_point_index);
    else if (st_r == S_RD0) ram_addr = AW'(cur_r);
    else ram_addr = AW'(cur_r + 7'd1);
  end

  assign out_target_heading  = hdg_r;
  assign out_target_velocity = vel_r;
  assign out_waypoint_now    = cur_r;
  assign out_arrived         = latch_r;
  assign out_route_done      = (cur_r > {1'b0, last_r});
endmodule
`default_nettype wire

// ----- rtl/wfsp_checker.sv -----
// Port-level checker for the waypoint follower, bound to the top level.
// Depends on waypoint_follower_speed_profile.
`default_nettype none
module wfsp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [15:0] out_target_heading
);
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transaction not busy");
  a_vld_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_vld_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double strobe");
  a_hdg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_target_heading < 16'd46080) else $error("heading range");
endmodule
bind waypoint_follower_speed_profile wfsp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_target_heading(out_target_heading));
`default_nettype wire

// ----- verif/waypoint_follower_speed_profile_tb.sv -----
// Testbench for waypoint_follower_speed_profile: a clocked driver and monitor checked
// against an in-bench predictor of bearing, distance, speed profile and route state.
// Depends on wfsp_pkg and the RTL of the block.
`timescale 1ns / 100ps
module waypoint_follower_speed_profile_tb;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  idx;
    logic [31:0] px, py, qx, qy;
    logic        hdg_ok;
  } nav_item_t;

  typedef struct packed {
    logic [15:0] hdg, vel;
    logic [6:0]  wp;
    logic        arr, done;
  } nav_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic in_command = 1'b0;
  logic [5:0] in_point_index = '0;
  logic [31:0] in_point_x = '0, in_point_y = '0, in_position_x = '0, in_position_y = '0;
  logic in_heading_reached = 1'b0;
  logic out_valid;
  logic [15:0] out_target_heading, out_target_velocity;
  logic [6:0] out_waypoint_now;
  logic out_arrived, out_route_done;

  waypoint_follower_speed_profile dut (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .in_command(in_command),
    .in_point_index(in_point_index), .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_position_x(in_position_x), .in_position_y(in_position_y),
    .in_heading_reached(in_heading_reached), .out_valid(out_valid),
    .out_target_heading(out_target_heading), .out_target_velocity(out_target_velocity),
    .out_waypoint_now(out_waypoint_now), .out_arrived(out_arrived),
    .out_route_done(out_route_done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted copy of registers and route state
  logic [15:0] m_max = wfsp_pkg::MaxSpeedRst, m_min = wfsp_pkg::MinSpeedRst;
  logic [31:0] m_brake = wfsp_pkg::BrakeRst, m_switch = wfsp_pkg::SwitchRst;
  logic [5:0]  m_first = '0, m_last = '0;
  logic [31:0] m_tx [64];
  logic [31:0] m_ty [64];
  logic [6:0]  m_wp = '0;
  logic        m_latch = 1'b0;
  logic [15:0] m_hdg = '0, m_vel = '0;

  nav_item_t pending_q[$];
  nav_out_t  expected_q[$];
  int fails = 0;
  int gap = 0;
  bit quiet = 0;
  int done_ticks = 0;

  // atan(2^-i) in 2^-16 degree
  const longint atan_deg[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  function automatic logic [15:0] bearing_of(longint dx, longint dy);
    longint unsigned ax, ay;
    longint x, y, z, a, xs, ys, h;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax == 0 && ay == 0) return 16'd0;
    while ((ax | ay) < (64'd1 << 40)) begin
      ax = ax << 1;
      ay = ay << 1;
    end
    x = ax; y = ay; z = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_deg[i];
      end else begin
        x -= ys; y += xs; z -= atan_deg[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    if (dx >= 0 && dy >= 0) a = z;
    else if (dx < 0 && dy >= 0) a = 180 * 65536 - z;
    else if (dx < 0) a = 180 * 65536 + z;
    else a = 360 * 65536 - z;
    h = (a + 256) >>> 9;
    if (h >= 46080) h -= 46080;
    return h[15:0];
  endfunction

  function automatic longint unsigned range_of(longint dx, longint dy);
    longint unsigned ax, ay, n, res, bitv;
    logic [64:0] s;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    s = {1'b0, ax * ax} + {1'b0, ay * ay};
    if (s[64]) return 64'd1 << 32;
    n = s[63:0]; res = 0; bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else res = res >> 1;
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] speed_at(longint unsigned d);
    longint unsigned term;
    if (d > m_brake) return m_max;
    if (m_max <= m_min || m_brake == 0) return m_min;
    term = (64'(m_max - m_min) * d * 7) / (64'(m_brake) * 10);
    return m_min + term[15:0];
  endfunction

  // advance the predicted state by one transaction, queue the expected result
  task automatic predict_nav(input nav_item_t it);
    longint dx, dy;
    longint unsigned d;
    logic [5:0] i, k;
    logic [15:0] ang, nxt;
    if (!it.cmd) begin
      m_tx[it.idx] = it.px;
      m_ty[it.idx] = it.py;
    end else if (m_wp > m_last) begin
      if (m_vel < m_min) m_vel = 16'd0;
      else m_vel = m_vel >= wfsp_pkg::BrakeStep ? m_vel - wfsp_pkg::BrakeStep : 16'd0;
    end else if (m_first < m_last) begin
      i = m_wp[5:0];
      dx = longint'($signed(m_tx[i])) - longint'($signed(it.qx));
      dy = longint'($signed(m_ty[i])) - longint'($signed(it.qy));
      ang = bearing_of(dx, dy);
      if (m_wp < m_last) begin
        k = i + 6'd1;
        nxt = bearing_of(longint'($signed(m_tx[k])) - longint'($signed(m_tx[i])),
                         longint'($signed(m_ty[k])) - longint'($signed(m_ty[i])));
      end else nxt = m_hdg;
      d = range_of(dx, dy);
      if (!m_latch) begin
        m_hdg = ang;
        m_vel = speed_at(d);
      end
      if (d < m_switch) m_latch = 1'b1;
      if (m_latch) begin
        m_hdg = nxt;
        m_vel = m_min;
        if (it.hdg_ok) begin
          m_wp = m_wp + 7'd1;
          m_latch = 1'b0;
        end
      end
    end
    expected_q.push_back('{m_hdg, m_vel, m_wp, m_latch, m_wp > m_last});
  endtask

  // driver: present pending items, random gaps between transactions
  always @(posedge clk) begin : drive
    logic take, nxt_start;
    nav_item_t it;
    take = start && !busy;
    if (take) begin
      it = '{in_command, in_point_index, in_point_x, in_point_y,
             in_position_x, in_position_y, in_heading_reached};
      predict_nav(it);
    end
    if (!(start && !take)) begin
      if (take && !quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
      if (gap > 0) begin
        gap--;
        nxt_start = 1'b0;
      end else if (pending_q.size() > 0) begin
        it = pending_q.pop_front();
        in_command <= it.cmd;
        in_point_index <= it.idx;
        in_point_x <= it.px;
        in_point_y <= it.py;
        in_position_x <= it.qx;
        in_position_y <= it.qy;
        in_heading_reached <= it.hdg_ok;
        nxt_start = 1'b1;
      end else nxt_start = 1'b0;
      start <= nxt_start;
    end
  end

  // monitor: compare each result strobe with the oldest expectation
  always @(posedge clk) begin : watch
    nav_out_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result hdg=%0d vel=%0d", $time,
                 out_target_heading, out_target_velocity);
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (out_target_heading !== e.hdg) begin
          $display("%0t: heading exp %0d got %0d", $time, e.hdg, out_target_heading);
          fails++;
        end
        if (out_target_velocity !== e.vel) begin
          $display("%0t: velocity exp %0d got %0d", $time, e.vel, out_target_velocity);
          fails++;
        end
        if (out_waypoint_now !== e.wp) begin
          $display("%0t: waypoint exp %0d got %0d", $time, e.wp, out_waypoint_now);
          fails++;
        end
        if (out_arrived !== e.arr) begin
          $display("%0t: arrived exp %0b got %0b", $time, e.arr, out_arrived);
          fails++;
        end
        if (out_route_done !== e.done) begin
          $display("%0t: route_done exp %0b got %0b", $time, e.done, out_route_done);
          fails++;
        end
      end
    end
  end

  // queue one transaction once the previous ones have been taken
  task automatic send(input nav_item_t it);
    do @(negedge clk); while (pending_q.size() != 0 || start);
    pending_q.push_back(it);
  endtask

  task automatic send_load(input logic [5:0] idx, input logic [31:0] x, input logic [31:0] y);
    send('{1'b0, idx, x, y, 32'($urandom), 32'($urandom), 1'($urandom)});
  endtask

  task automatic send_tick(input logic [31:0] x, input logic [31:0] y, input logic ok);
    send('{1'b1, 6'($urandom), 32'($urandom), 32'($urandom), x, y, ok});
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_q.size() != 0 || start || expected_q.size() != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input wfsp_pkg::reg_idx_t r, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      wfsp_pkg::REG_MAX:    m_max = v[15:0];
      wfsp_pkg::REG_MIN:    m_min = v[15:0];
      wfsp_pkg::REG_BRAKE:  m_brake = v;
      wfsp_pkg::REG_SWITCH: m_switch = v;
      wfsp_pkg::REG_FIRST: begin
        m_first = v[5:0]; m_wp = {1'b0, v[5:0]}; m_latch = 1'b0;
      end
      wfsp_pkg::REG_LAST:   m_last = v[5:0];
      default: ;
    endcase
  endtask

  task automatic set_route(input logic [15:0] mx, input logic [15:0] mn, input logic [31:0] br,
                           input logic [31:0] sw, input logic [5:0] f, input logic [5:0] l);
    wait_idle();
    write_reg(wfsp_pkg::REG_MAX, {16'd0, mx});
    write_reg(wfsp_pkg::REG_MIN, {16'd0, mn});
    write_reg(wfsp_pkg::REG_BRAKE, br);
    write_reg(wfsp_pkg::REG_SWITCH, sw);
    write_reg(wfsp_pkg::REG_LAST, {26'd0, l});
    write_reg(wfsp_pkg::REG_FIRST, {26'd0, f});
  endtask

  // random offset in [-r, r]
  function automatic longint jitter(longint r);
    longint o;
    o = (r * $urandom_range(0, 1000)) / 1000;
    return $urandom_range(0, 1) ? -o : o;
  endfunction

  // tick placed relative to the current waypoint
  task automatic route_tick();
    longint r, bx, by;
    int mode;
    logic [5:0] i;
    do @(negedge clk); while (pending_q.size() != 0 || start);
    i = m_wp[5:0];
    bx = $signed(m_tx[i]); by = $signed(m_ty[i]);
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2: r = m_switch / 2;
      3, 4, 5: r = m_brake / 2;
      6, 7:    r = longint'(m_brake) * 3;
      default: r = 0;
    endcase
    if (mode == 8) send_tick(32'($urandom), 32'($urandom), 1'($urandom));
    else send_tick(32'(bx - jitter(r)), 32'(by - jitter(r)), 1'($urandom));
  endtask

  task automatic lay_route(input logic [5:0] f, input logic [5:0] l);
    longint x, y, step;
    logic [5:0] s;
    x = jitter(64'd3_000_000); y = jitter(64'd3_000_000);
    step = 65536 * $urandom_range(1, 40);
    for (int n = f; n <= l + 1; n++) begin
      s = 6'(n);
      if ($urandom_range(0, 15) == 0) send_load(s, 32'($urandom), 32'($urandom));
      else send_load(s, 32'(x), 32'(y));
      x += jitter(step); y += jitter(step);
    end
  endtask

  initial begin : stimulus
    int total;
    int p;
    int n;
    logic [15:0] mx, mn;
    logic [31:0] br, sw;
    logic [5:0] f, l;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // fill every slot so no tick reads an unwritten entry
    for (int s = 0; s < 64; s++) send_load(6'(s), 32'($urandom), 32'($urandom));

    // directed: idle route at reset, then a three-point route end to end
    send_tick(32'h0, 32'h0, 1'b1);
    send_load(6'd0, 32'h0, 32'h0);
    send_load(6'd1, 32'd655360, 32'h0);
    send_load(6'd2, 32'd655360, 32'd655360);
    send_load(6'd3, 32'h0, 32'd655360);
    set_route(wfsp_pkg::MaxSpeedRst, wfsp_pkg::MinSpeedRst, wfsp_pkg::BrakeRst,
              wfsp_pkg::SwitchRst, 6'd0, 6'd2);
    send_tick(-32'sd655360, 32'h0, 1'b0);          // far: cruise
    send_tick(-32'sd131072, 32'h0, 1'b1);          // inside braking distance
    send_tick(32'h7FFFFFFF, 32'h80000000, 1'b0);    // coordinate extremes
    send_tick(32'h80000000, 32'h7FFFFFFF, 1'b1);
    send_tick(32'h0, 32'h0, 1'b0);                  // zero vector, latches reached
    send_tick(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);    // latched: far position ignored
    send_tick(32'h0, 32'h0, 1'b1);                  // heading reached: advance
    send_tick(32'd650000, 32'd1000, 1'b1);          // reach point 1, advance
    send_tick(32'd655360, 32'd600000, 1'b0);        // approach last point
    send_tick(32'd655360, 32'd655360, 1'b1);        // last point: past the route
    send_tick(32'h0, 32'h0, 1'b0);                  // braking
    send_tick(32'h0, 32'h0, 1'b1);
    send_load(6'd63, 32'h80000000, 32'h7FFFFFFF);
    send_load(6'd62, 32'h7FFFFFFF, 32'h80000000);

    // random phases, extremes first
    total = 0; p = 0;
    while (total < 1950) begin
      case (p)
        0: begin mx = 16'hFFFF; mn = '0; br = 32'hFFFFFFFF; sw = '0; f = '0; l = 6'd63; end
        1: begin mx = '0; mn = 16'hFFFF; br = 32'd1; sw = 32'hFFFFFFFF; f = 6'd62; l = 6'd63; end
        2: begin mx = 16'd3000; mn = 16'd100; br = wfsp_pkg::BrakeRst;
                 sw = wfsp_pkg::SwitchRst; f = 6'd63; l = 6'd63; end
        3: begin mx = 16'd3000; mn = 16'd100; br = wfsp_pkg::BrakeRst;
                 sw = wfsp_pkg::SwitchRst; f = 6'd9; l = 6'd4; end
        default: begin
          mx = 16'($urandom_range(0, 65535));
          mn = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, mx));
          br = 65536 * $urandom_range(1, 20) + $urandom_range(0, 65535);
          sw = $urandom_range(0, 7) == 0 ? 32'($urandom) : 32'($urandom_range(8192, br));
          f = 6'($urandom_range(0, 60));
          l = 6'(f + $urandom_range(1, 3));
        end
      endcase
      if (p != 1) lay_route(f, l);
      set_route(mx, mn, br, sw, f, l);
      done_ticks = 0;
      n = 0;
      while (n < 150 && done_ticks < 20 && total < 1950) begin
        if ($urandom_range(0, 19) == 0)
          send_load(6'($urandom), 32'($urandom), 32'($urandom));
        else begin
          if (m_wp > m_last) done_ticks++;
          route_tick();
        end
        n++; total++;
        quiet = (total > 1750);
      end
      p++;
    end

    wait_idle();
    repeat (250) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
